[hw/rtl/wsi_pkg.sv]
// shared types and constants for the wav sample to int16 converter
// used by wsi_front, wsi_queue, wsi_back and wav_sample_to_int16
package wsi_pkg;

  localparam int MAX_SAMPLE_BYTES = 8;
  localparam int SAMPLE_W         = MAX_SAMPLE_BYTES * 8;
  localparam int GATHER_W         = (MAX_SAMPLE_BYTES - 1) * 8;
  localparam int CNT_W            = $clog2(MAX_SAMPLE_BYTES);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic CFG_AUDIO_FORMAT     = 1'b0;
  localparam logic CFG_BYTES_PER_SAMPLE = 1'b1;

  localparam logic [15:0] SAT_POS = 16'h7fff;
  localparam logic [15:0] SAT_NEG = 16'h8000;

  typedef enum logic [2:0] {
    KIND_PCM8  = 3'd0,
    KIND_PCM16 = 3'd1,
    KIND_PCM24 = 3'd2,
    KIND_PCM32 = 3'd3,
    KIND_FLT32 = 3'd4,
    KIND_FLT64 = 3'd5,
    KIND_UNSUP = 3'd6
  } kind_t;

  // one complete sample handed from front to back
  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] bits;
  } entry_t;

  // decoded sample between the two back stages
  typedef struct packed {
    logic        direct;
    logic [15:0] value;
    logic        unsup;
    logic        neg;
    logic [7:0]  exp;
    logic [23:0] sig;
  } decode_t;

endpackage

[hw/rtl/wsi_front.sv]
// front part: config registers, byte gathering and sample classification
// depends on wsi_pkg
module wsi_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  restart,
  output logic                  push,
  output wsi_pkg::entry_t       push_entry
);

  logic [15:0]                  audio_format;
  logic [3:0]                   bytes_per_sample;
  logic [wsi_pkg::GATHER_W-1:0] gathered;
  logic [wsi_pkg::CNT_W-1:0]    byte_count;

  logic [wsi_pkg::GATHER_W-1:0] gath_eff;
  logic [wsi_pkg::GATHER_W-1:0] gathered_next;
  logic [wsi_pkg::CNT_W-1:0]    cnt_eff;
  logic [3:0]                   n;
  logic [wsi_pkg::CNT_W-1:0]    nm1;
  logic                         done;
  logic [wsi_pkg::SAMPLE_W-1:0] v;
  wsi_pkg::kind_t               kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_format     <= wsi_pkg::FMT_PCM;
      bytes_per_sample <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsi_pkg::CFG_AUDIO_FORMAT:     audio_format     <= cfg_data;
        wsi_pkg::CFG_BYTES_PER_SAMPLE: bytes_per_sample <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gath_eff = restart ? '0 : gathered;
    cnt_eff  = restart ? '0 : byte_count;
    // gathering length forced into 1..max
    if (bytes_per_sample == 4'd0) begin
      n = 4'd1;
    end else if (bytes_per_sample > 4'(wsi_pkg::MAX_SAMPLE_BYTES)) begin
      n = 4'(wsi_pkg::MAX_SAMPLE_BYTES);
    end else begin
      n = bytes_per_sample;
    end
    nm1  = wsi_pkg::CNT_W'(n - 4'd1);
    done = (4'({1'b0, cnt_eff}) + 4'd1) >= n;

    // only held bytes below the last position are used
    v = '0;
    for (int i = 0; i < wsi_pkg::MAX_SAMPLE_BYTES - 1; i++) begin
      if (wsi_pkg::CNT_W'(i) < nm1) begin
        v[i*8 +: 8] = gath_eff[i*8 +: 8];
      end
    end
    v[nm1*8 +: 8] = data_byte;

    gathered_next = gath_eff;
    for (int i = 0; i < wsi_pkg::MAX_SAMPLE_BYTES - 1; i++) begin
      if (cnt_eff == wsi_pkg::CNT_W'(i)) begin
        gathered_next[i*8 +: 8] = data_byte;
      end
    end

    kind = wsi_pkg::KIND_UNSUP;
    if (audio_format == wsi_pkg::FMT_PCM) begin
      unique case (bytes_per_sample)
        4'd1:    kind = wsi_pkg::KIND_PCM8;
        4'd2:    kind = wsi_pkg::KIND_PCM16;
        4'd3:    kind = wsi_pkg::KIND_PCM24;
        4'd4:    kind = wsi_pkg::KIND_PCM32;
        default: kind = wsi_pkg::KIND_UNSUP;
      endcase
    end else if (audio_format == wsi_pkg::FMT_FLOAT) begin
      unique case (bytes_per_sample)
        4'd4:    kind = wsi_pkg::KIND_FLT32;
        4'd8:    kind = wsi_pkg::KIND_FLT64;
        default: kind = wsi_pkg::KIND_UNSUP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gathered   <= '0;
      byte_count <= '0;
    end else if (accept) begin
      if (done) begin
        gathered   <= '0;
        byte_count <= '0;
      end else begin
        gathered   <= gathered_next;
        byte_count <= cnt_eff + 1'b1;
      end
    end
  end

  assign push            = accept && done;
  assign push_entry.kind = kind;
  assign push_entry.bits = v;

endmodule

[hw/rtl/wsi_queue.sv]
// short register queue of complete samples between front and back
// depends on wsi_pkg
module wsi_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsi_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output wsi_pkg::entry_t head
);

  wsi_pkg::entry_t             slots [wsi_pkg::QUEUE_DEPTH];
  logic [wsi_pkg::QPTR_W-1:0]  wr_ptr;
  logic [wsi_pkg::QPTR_W-1:0]  rd_ptr;
  logic [wsi_pkg::QPTR_W:0]    count;
  logic                        do_pop;

  assign full   = count == (wsi_pkg::QPTR_W+1)'(wsi_pkg::QUEUE_DEPTH);
  assign valid  = count != '0;
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/wsi_back.sv]
// back part: decode and round, then scale to int16 into the output register
// depends on wsi_pkg
module wsi_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  wsi_pkg::entry_t in_entry,
  output logic            in_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     sample,
  output logic            unsupported
);

  logic             pipe_en;
  logic             s1_valid;
  wsi_pkg::decode_t s1;
  wsi_pkg::decode_t dec;

  logic [63:0] v;
  logic [10:0] e64;
  logic [51:0] m64;
  logic [23:0] r;
  logic [24:0] r_inc;
  logic        round_up;
  logic [7:0]  fe;

  logic [7:0]  shift;
  logic [15:0] mag;
  logic [15:0] fixed;

  // whole back pipeline moves when the output register can take an item
  assign pipe_en = !out_valid || out_ready;
  assign in_pop  = pipe_en && in_valid;

  always_comb begin
    v     = in_entry.bits;
    e64   = v[62:52];
    m64   = v[51:0];
    r     = {1'b1, m64[51:29]};
    round_up = m64[28] && ((m64[27:0] != '0) || r[0]);
    r_inc = {1'b0, r} + 25'(round_up);
    fe    = 8'(e64 - 11'd896);

    dec        = '0;
    dec.direct = 1'b1;
    unique case (in_entry.kind)
      wsi_pkg::KIND_PCM8:  dec.value = {~v[7], v[6:0], 8'h00};
      wsi_pkg::KIND_PCM16: dec.value = v[15:0];
      wsi_pkg::KIND_PCM24: dec.value = v[23:8];
      wsi_pkg::KIND_PCM32: dec.value = v[31:16];
      wsi_pkg::KIND_FLT32: begin
        if (v[30:23] == 8'hff) begin
          // nan gives zero, infinities saturate
          if (v[22:0] != '0) begin
            dec.value = 16'h0000;
          end else begin
            dec.value = v[31] ? wsi_pkg::SAT_NEG : wsi_pkg::SAT_POS;
          end
        end else begin
          dec.direct = 1'b0;
          dec.neg    = v[31];
          dec.exp    = v[30:23];
          dec.sig    = {1'b1, v[22:0]};
        end
      end
      wsi_pkg::KIND_FLT64: begin
        if (e64 == 11'h7ff && m64 != '0) begin
          dec.value = 16'h0000;
        end else if (e64 >= 11'd1023) begin
          dec.value = v[63] ? wsi_pkg::SAT_NEG : wsi_pkg::SAT_POS;
        end else if (e64 < 11'd897) begin
          dec.value = 16'h0000;
        end else begin
          dec.direct = 1'b0;
          dec.neg    = v[63];
          // carry out of the rounding raises the exponent
          if (r_inc[24]) begin
            dec.exp = fe + 8'd1;
            dec.sig = r_inc[24:1];
          end else begin
            dec.exp = fe;
            dec.sig = r_inc[23:0];
          end
        end
      end
      wsi_pkg::KIND_UNSUP: begin
        dec.value = 16'h0000;
        dec.unsup = 1'b1;
      end
      default: begin
        dec.value = 16'h0000;
        dec.unsup = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1 <= dec;
    end
  end

  // value times 32768, truncated toward zero; magnitudes of 1.0 or more saturate
  always_comb begin
    shift = 8'd135 - s1.exp;
    mag   = (shift >= 8'd32) ? 16'h0000 : 16'(s1.sig >> shift[4:0]);
    if (s1.direct) begin
      fixed = s1.value;
    end else if (s1.exp >= 8'd127) begin
      fixed = s1.neg ? wsi_pkg::SAT_NEG : wsi_pkg::SAT_POS;
    end else if (s1.exp == 8'd0) begin
      fixed = 16'h0000;
    end else begin
      fixed = s1.neg ? (16'h0000 - mag) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sample      <= fixed;
      unsupported <= s1.unsup;
    end
  end

endmodule

[hw/rtl/wav_sample_to_int16.sv]
// wav sample to int16 converter: byte stream in, signed 16-bit samples out
// depends on wsi_pkg, wsi_front, wsi_queue, wsi_back
//
// s_tdata carries one stream byte, least significant byte of a sample first;
// s_tuser set on a byte drops any partly gathered sample before that byte.
// audio_format (index 0) and bytes_per_sample (index 1) are set through
// cfg_we/cfg_index/cfg_data; the user must do so only while no sample is in
// flight, as the block does not enforce it. Every bytes_per_sample bytes
// (clamped to 1..8) give one item on the master side: m_tdata is the signed
// sample, m_tuser flags an unsupported format and width (sample 0). One byte
// is taken per clock while the queue is not full. m_tvalid rises once the
// last byte of a sample has been written to the queue, loaded into the decode
// and round stage and then, as the scale stage result, into the output
// register. The two back stages take a new sample while earlier ones are
// still in them. When m_tready is low the back stages hold; bytes keep
// flowing in until the four-entry sample queue fills, then s_tready drops.
// Reset (rst, synchronous) returns format 1, width 2 and empties the
// gatherer, the queue and the output register.
module wav_sample_to_int16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample
  output logic [0:0]  m_tuser,   // [0] unsupported
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic            accept;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  wsi_pkg::entry_t push_entry;
  wsi_pkg::entry_t head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  wsi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .data_byte  (s_tdata),
    .restart    (s_tuser[0]),
    .push       (push),
    .push_entry (push_entry)
  );

  wsi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head)
  );

  wsi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_entry    (head),
    .in_pop      (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .sample      (m_tdata),
    .unsupported (m_tuser[0])
  );

endmodule
